// ----- sv/rtc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, codes and character helpers for the route transposition
// cipher.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int CHAR_W = 16;
  localparam int COL_W  = 6;
  localparam int ST_W   = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 16'h0058;  // 'X'
  localparam logic [CHAR_W-1:0] CH_YO_LC = 16'h0451;  // small io
  localparam logic [CHAR_W-1:0] CH_YO_UC = 16'h0401;  // capital io
  localparam logic [CHAR_W-1:0] CASE_OFS = 16'h0020;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_OVF   = 2'd2
  } rtc_status_t;

  // Configuration register indexes
  localparam logic CFG_IDX_COLS = 1'b0;
  localparam logic CFG_IDX_DIR  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_ROWS,
    S_BASE,
    S_SCAN,
    S_EMIT,
    S_STATUS
  } rtc_state_t;

  // Buffer control from the sequencer
  typedef struct packed {
    logic wr_en;  // store a cleaned character (if not blank)
    logic clr;    // drop message: count and overflow back to zero
  } rtc_buf_ctl_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    is_blank = (c == 16'h0020) || (c == 16'h0009) || (c == 16'h000A) ||
               (c == 16'h000D);
  endfunction

  function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if ((c >= 16'h0061 && c <= 16'h007A) || (c >= 16'h0430 && c <= 16'h044F)) begin
      r = c - CASE_OFS;
    end else if (c == CH_YO_LC) begin
      r = CH_YO_UC;
    end
    to_upper = r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/rtc_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_alu
// Shared add/subtract unit: row count accumulation, table base and cell
// position stepping all go through this one adder.
// ----------------------------------------------------------------------------
module rtc_alu #(
  parameter int POS_W = 7
) (
  input  wire logic [POS_W-1:0] a,
  input  wire logic [POS_W-1:0] b,
  input  wire logic             sub,
  output logic      [POS_W-1:0] y
);

  // y = a + b or a - b, modulo 2^POS_W
  assign y = sub ? (a - b) : (a + b);

endmodule
`default_nettype wire

// ----- sv/rtc_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_buf
// Input cleaning and text buffer: drops whitespace, upper-cases letters,
// stores characters and tracks count and overflow.
// ----------------------------------------------------------------------------
module rtc_buf #(
  parameter int MAX_CHARS = 15,
  localparam int CW = $clog2(MAX_CHARS + 1),
  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rtc_pkg::rtc_buf_ctl_t      ctl,
  input  wire logic [rtc_pkg::CHAR_W-1:0] in_char,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [rtc_pkg::CHAR_W-1:0] rd_data,
  output logic      [CW-1:0]              count,
  output logic                            ovf
);

  logic [rtc_pkg::CHAR_W-1:0] mem_r [MAX_CHARS];
  logic [CW-1:0]              count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       store;
  logic                       full;

  assign full  = (count_r == CW'(MAX_CHARS));
  assign store = ctl.wr_en && !rtc_pkg::is_blank(in_char);

  // Count and overflow
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (ctl.clr) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (store) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Character store, no reset needed
  always_ff @(posedge clk) begin
    if (store && !full) begin
      mem_r[count_r[AW-1:0]] <= rtc_pkg::to_upper(in_char);
    end
  end

  assign rd_data = mem_r[rd_addr];
  assign count   = count_r;
  assign ovf     = ovf_r;

endmodule
`default_nettype wire

// ----- sv/rtc_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_seq
// Sequencer: sizes the table, walks the transposition route through the
// shared adder, trims trailing pads on decrypt and drives the result register.
// ----------------------------------------------------------------------------
module rtc_seq #(
  parameter int MAX_CHARS   = 15,
  parameter int MAX_COLUMNS = 50,
  localparam int CW    = $clog2(MAX_CHARS + 1),
  localparam int AW    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1,
  localparam int POS_W = $clog2(MAX_CHARS + MAX_COLUMNS + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input handshake
  input  wire logic                       in_tvalid,
  input  wire logic                       in_tlast,
  output logic                            in_tready,
  // configuration
  input  wire logic [rtc_pkg::COL_W-1:0]  cfg_cols,
  input  wire logic                       cfg_dir,
  // buffer
  output rtc_pkg::rtc_buf_ctl_t           buf_ctl,
  output logic      [AW-1:0]              rd_addr,
  input  wire logic [rtc_pkg::CHAR_W-1:0] rd_data,
  input  wire logic [CW-1:0]              count,
  input  wire logic                       ovf,
  // result register
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [rtc_pkg::CHAR_W-1:0] out_char,
  output logic                            out_has,
  output logic      [rtc_pkg::ST_W-1:0]   out_st,
  output logic                            out_eom
);

  localparam int COL_W = rtc_pkg::COL_W;

  rtc_pkg::rtc_state_t   state_r, state_nxt;
  rtc_pkg::rtc_status_t  st_r, st_nxt;
  logic [COL_W-1:0]      cols_r, cols_nxt;
  logic                  dir_r, dir_nxt;
  logic                  scanned_r, scanned_nxt;
  logic [CW-1:0]         rows_r, rows_nxt;
  logic [POS_W-1:0]      acc_r, acc_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [POS_W-1:0]      cstart_r, cstart_nxt;
  logic [COL_W-1:0]      c_r, c_nxt;
  logic [POS_W-1:0]      k_r, k_nxt;
  logic [POS_W-1:0]      n_r, n_nxt;

  logic                  ov_r, ov_nxt;
  logic [rtc_pkg::CHAR_W-1:0] oc_r, oc_nxt;
  logic                  oh_r, oh_nxt;
  logic [rtc_pkg::ST_W-1:0] os_r, os_nxt;
  logic                  oe_r, oe_nxt;

  logic [POS_W-1:0]      alu_a, alu_b, alu_y;
  logic                  alu_sub;
  logic                  in_acc;
  logic                  out_free;
  logic [COL_W-1:0]      inner_lim;
  logic                  inner_end;
  logic [POS_W-1:0]      k_inc;
  logic [rtc_pkg::CHAR_W-1:0] tbl_char;

  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !ov_r || out_ready;
  assign inner_lim = dir_r ? cols_r : COL_W'(rows_r);
  assign inner_end = ((c_r + COL_W'(1)) == inner_lim);
  assign k_inc     = k_r + POS_W'(1);

  // Cell of the table: stored character or pad beyond the text
  assign rd_addr  = pos_r[AW-1:0];
  assign tbl_char = (pos_r < POS_W'(count)) ? rd_data : rtc_pkg::PAD_CHAR;

  rtc_alu #(.POS_W(POS_W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  // Operand selection for the shared adder
  always_comb begin
    // route step: encrypt walks down a column (+cols, next column -1),
    // decrypt walks across a row (-rows, next row +1)
    alu_a   = inner_end ? cstart_r : pos_r;
    alu_b   = inner_end ? POS_W'(1) : (dir_r ? POS_W'(rows_r) : POS_W'(cols_r));
    alu_sub = dir_r ? !inner_end : inner_end;
    unique case (state_r)
      rtc_pkg::S_ROWS: begin
        alu_a   = acc_r;
        alu_b   = POS_W'(cols_r);
        alu_sub = 1'b0;
      end
      rtc_pkg::S_BASE: begin
        alu_a   = dir_r ? acc_r : POS_W'(cols_r);
        alu_b   = dir_r ? POS_W'(rows_r) : POS_W'(1);
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state and outputs
  always_comb begin
    state_nxt   = state_r;
    st_nxt      = st_r;
    cols_nxt    = cols_r;
    dir_nxt     = dir_r;
    scanned_nxt = scanned_r;
    rows_nxt    = rows_r;
    acc_nxt     = acc_r;
    pos_nxt     = pos_r;
    cstart_nxt  = cstart_r;
    c_nxt       = c_r;
    k_nxt       = k_r;
    n_nxt       = n_r;
    ov_nxt      = ov_r && !out_ready;
    oc_nxt      = oc_r;
    oh_nxt      = oh_r;
    os_nxt      = os_r;
    oe_nxt      = oe_r;
    buf_ctl     = '0;
    in_tready   = 1'b0;

    unique case (state_r)
      rtc_pkg::S_LOAD: begin
        in_tready     = 1'b1;
        buf_ctl.wr_en = in_acc;
        if (in_acc && in_tlast) begin
          state_nxt = rtc_pkg::S_START;
        end
      end
      rtc_pkg::S_START: begin
        // key clamp and error checks
        if (cfg_cols == '0) begin
          cols_nxt = COL_W'(1);
        end else if (cfg_cols > COL_W'(MAX_COLUMNS)) begin
          cols_nxt = COL_W'(MAX_COLUMNS);
        end else begin
          cols_nxt = cfg_cols;
        end
        dir_nxt     = cfg_dir;
        scanned_nxt = 1'b0;
        rows_nxt    = '0;
        acc_nxt     = '0;
        if (ovf) begin
          st_nxt    = rtc_pkg::STAT_OVF;
          state_nxt = rtc_pkg::S_STATUS;
        end else if (count == '0) begin
          st_nxt    = rtc_pkg::STAT_EMPTY;
          state_nxt = rtc_pkg::S_STATUS;
        end else begin
          state_nxt = rtc_pkg::S_ROWS;
        end
      end
      rtc_pkg::S_ROWS: begin
        // rows = ceil(count/cols); acc ends at rows*cols
        if (acc_r < POS_W'(count)) begin
          acc_nxt  = alu_y;
          rows_nxt = rows_r + CW'(1);
        end else begin
          state_nxt = rtc_pkg::S_BASE;
        end
      end
      rtc_pkg::S_BASE: begin
        // start of route: encrypt cols-1, decrypt (cols-1)*rows
        pos_nxt    = alu_y;
        cstart_nxt = alu_y;
        c_nxt      = '0;
        k_nxt      = '0;
        if (!dir_r) begin
          n_nxt     = acc_r;
          state_nxt = rtc_pkg::S_EMIT;
        end else if (!scanned_r) begin
          n_nxt     = '0;
          state_nxt = rtc_pkg::S_SCAN;
        end else if (n_r == '0) begin
          st_nxt    = rtc_pkg::STAT_OK;
          state_nxt = rtc_pkg::S_STATUS;
        end else begin
          state_nxt = rtc_pkg::S_EMIT;
        end
      end
      rtc_pkg::S_SCAN: begin
        // find length up to last non-pad character
        if (tbl_char != rtc_pkg::PAD_CHAR) begin
          n_nxt = k_inc;
        end
        k_nxt   = k_inc;
        pos_nxt = alu_y;
        if (inner_end) begin
          c_nxt      = '0;
          cstart_nxt = alu_y;
        end else begin
          c_nxt = c_r + COL_W'(1);
        end
        if (k_inc == acc_r) begin
          scanned_nxt = 1'b1;
          state_nxt   = rtc_pkg::S_BASE;
        end
      end
      rtc_pkg::S_EMIT: begin
        if (out_free) begin
          ov_nxt  = 1'b1;
          oc_nxt  = tbl_char;
          oh_nxt  = 1'b1;
          os_nxt  = rtc_pkg::STAT_OK;
          oe_nxt  = (k_inc == n_r);
          k_nxt   = k_inc;
          pos_nxt = alu_y;
          if (inner_end) begin
            c_nxt      = '0;
            cstart_nxt = alu_y;
          end else begin
            c_nxt = c_r + COL_W'(1);
          end
          if (k_inc == n_r) begin
            buf_ctl.clr = 1'b1;
            state_nxt   = rtc_pkg::S_LOAD;
          end
        end
      end
      rtc_pkg::S_STATUS: begin
        // single result without a character
        if (out_free) begin
          ov_nxt      = 1'b1;
          oc_nxt      = '0;
          oh_nxt      = 1'b0;
          os_nxt      = st_r;
          oe_nxt      = 1'b1;
          buf_ctl.clr = 1'b1;
          state_nxt   = rtc_pkg::S_LOAD;
        end
      end
      default: begin
        state_nxt = rtc_pkg::S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtc_pkg::S_LOAD;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    st_r      <= st_nxt;
    cols_r    <= cols_nxt;
    dir_r     <= dir_nxt;
    scanned_r <= scanned_nxt;
    rows_r    <= rows_nxt;
    acc_r     <= acc_nxt;
    pos_r     <= pos_nxt;
    cstart_r  <= cstart_nxt;
    c_r       <= c_nxt;
    k_r       <= k_nxt;
    n_r       <= n_nxt;
    oc_r      <= oc_nxt;
    oh_r      <= oh_nxt;
    os_r      <= os_nxt;
    oe_r      <= oe_nxt;
  end

  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_has   = oh_r;
  assign out_st    = os_r;
  assign out_eom   = oe_r;

endmodule
`default_nettype wire

// ----- sv/route_transposition_cipher_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// route_transposition_cipher_top
// Columnar route transposition over 16-bit characters with a stream
// interface and a two-register configuration port.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle; whitespace is dropped and letters are
// upper-cased into a MAX_CHARS-entry buffer. The transfer with in_tlast set
// closes the message; in_tready then stays low until the last result has
// been handed to the output register. Sizing the table makes one pass of
// the shared adder per row (rows = ceil(count/columns)). Encrypt then gives
// rows*columns results, one per cycle while the output register is free.
// Decrypt first walks the whole route once (rows*columns cells) to find the
// trailing pads, then gives one result per cycle on the same condition.
// Error and empty cases give a single result. Results wait in one output
// register; a stalled out_tready stalls the route walk.
// ----------------------------------------------------------------------------
module route_transposition_cipher_top #(
  parameter int MAX_CHARS   = 15,
  parameter int MAX_COLUMNS = 50
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] character
  input  wire logic        in_tlast,   // last character of the message
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [15:0] out_character
  output logic      [2:0]  out_tuser,  // [0] has_char, [2:1] status
  output logic             out_tlast,  // end_of_message
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,   // 0 column_count, 1 direction
  input  wire logic [5:0]  cfg_wdata
);

  localparam int CW = $clog2(MAX_CHARS + 1);
  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  logic [rtc_pkg::COL_W-1:0]  cols_r;
  logic                       dir_r;
  rtc_pkg::rtc_buf_ctl_t      buf_ctl;
  logic [AW-1:0]              rd_addr;
  logic [rtc_pkg::CHAR_W-1:0] rd_data;
  logic [CW-1:0]              count;
  logic                       ovf;
  logic                       out_has;
  logic [rtc_pkg::ST_W-1:0]   out_st;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= rtc_pkg::COL_W'(1);
      dir_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rtc_pkg::CFG_IDX_COLS: cols_r <= cfg_wdata;
        rtc_pkg::CFG_IDX_DIR:  dir_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  rtc_buf #(.MAX_CHARS(MAX_CHARS)) u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (buf_ctl),
    .in_char (in_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .count   (count),
    .ovf     (ovf)
  );

  rtc_seq #(
    .MAX_CHARS   (MAX_CHARS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .cfg_cols  (cols_r),
    .cfg_dir   (dir_r),
    .buf_ctl   (buf_ctl),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .count     (count),
    .ovf       (ovf),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_has   (out_has),
    .out_st    (out_st),
    .out_eom   (out_tlast)
  );

  assign out_tuser = {out_st, out_has};

endmodule
`default_nettype wire

// ----- tb/tb_route_transposition_cipher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_route_transposition_cipher_top
// Self-checking bench for the route transposition cipher.
// ----------------------------------------------------------------------------
// A short table of directed messages (case folding limits, whitespace, key
// clamping, all-pad decrypt, overflow, a key change inside a message) is
// followed by random messages in four idle/stall phases. Each accepted
// character runs through a behavioral cipher model that queues the expected
// result transfers; the output monitor checks every result against the
// oldest queued one. Registers are only written with nothing in flight.
// ----------------------------------------------------------------------------
module tb_route_transposition_cipher_top;
  import rtc_pkg::*;

  localparam int DEPTH     = 15;   // character buffer depth
  localparam int MAX_COLS  = 50;
  localparam int SETTLE    = 8;    // quiet cycles before a register write
  localparam int LONG_HOLD = 300;  // receiver hold-off for backpressure
  localparam int PHASE_LEN = 100;  // random characters per phase
  localparam int TAIL      = 64;   // cycles watched after the last result
  localparam int N_ROWS    = 25;

  // One result transfer as the bench sees it
  typedef struct packed {
    logic [15:0] ch;
    logic        has;
    rtc_status_t st;
    logic        eom;
  } cipher_res_t;

  typedef enum logic {ROW_XFER, ROW_CFG} row_kind_t;

  // Directed row: a character (repeated reps times) or a register write
  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] data;
    logic [4:0]  reps;
    logic        last;
    logic        sel;
    logic        typed;
    cipher_res_t want;
  } stim_row_t;

  localparam cipher_res_t RES_NONE  = '0;
  localparam cipher_res_t RES_A     = '{16'h0041, 1'b1, STAT_OK, 1'b1};
  localparam cipher_res_t RES_EMPTY = '{16'h0000, 1'b0, STAT_EMPTY, 1'b1};
  localparam cipher_res_t RES_OVF   = '{16'h0000, 1'b0, STAT_OVF, 1'b1};
  localparam cipher_res_t RES_PAD   = '{16'h0000, 1'b0, STAT_OK, 1'b1};

  // Directed messages; results typed in only where obvious
  stim_row_t dir_rows [N_ROWS] = '{
    '{ROW_XFER, 16'h0061, 5'd1,  1'b1, CFG_IDX_COLS, 1'b1, RES_A},     // 'a', key 1
    '{ROW_XFER, 16'h0020, 5'd1,  1'b1, CFG_IDX_COLS, 1'b1, RES_EMPTY}, // blank only
    '{ROW_CFG,  16'h0000, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},  // key 0 -> 1
    '{ROW_XFER, 16'h0000, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_XFER, 16'h0009, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_XFER, 16'hFFFF, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_XFER, 16'h007A, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_XFER, 16'h0451, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_XFER, 16'h000A, 5'd1,  1'b1, CFG_IDX_COLS, 1'b0, RES_NONE},  // blank last
    '{ROW_CFG,  16'h003F, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},  // key 63 -> 50
    '{ROW_CFG,  16'h0001, 5'd1,  1'b0, CFG_IDX_DIR,  1'b0, RES_NONE},  // decrypt
    '{ROW_XFER, 16'h0058, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_XFER, 16'h0078, 5'd1,  1'b1, CFG_IDX_COLS, 1'b1, RES_PAD},   // only pads
    '{ROW_XFER, 16'h0430, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_XFER, 16'h000D, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_CFG,  16'h0002, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},  // key change mid-msg
    '{ROW_XFER, 16'h044F, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_XFER, 16'h0060, 5'd1,  1'b1, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_CFG,  16'h0000, 5'd1,  1'b0, CFG_IDX_DIR,  1'b0, RES_NONE},  // encrypt
    '{ROW_CFG,  16'h0032, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},  // key 50
    '{ROW_XFER, 16'h0452, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_XFER, 16'h0450, 5'd1,  1'b1, CFG_IDX_COLS, 1'b0, RES_NONE},  // 50 results
    '{ROW_CFG,  16'h0004, 5'd1,  1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},
    '{ROW_XFER, 16'h0031, 5'd15, 1'b0, CFG_IDX_COLS, 1'b0, RES_NONE},  // fill buffer
    '{ROW_XFER, 16'h0032, 5'd1,  1'b1, CFG_IDX_COLS, 1'b1, RES_OVF}    // one too many
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = CFG_IDX_COLS;
  logic [5:0]  cfg_wdata  = '0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [15:0] out_tdata;
  wire  [2:0]  out_tuser;
  wire         out_tlast;

  // Cipher model state and bookkeeping
  logic [15:0] text_mem [DEPTH];
  int          fill_cnt  = 0;
  bit          ovf_seen  = 1'b0;
  logic [5:0]  key_cols  = 6'd1;
  bit          dir_dec   = 1'b0;
  cipher_res_t route_out [$];
  cipher_res_t expected_q [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int hold_left = 0;

  int fail_cnt = 0;
  int xfer_cnt = 0;
  int char_cnt = 0;
  int msg_cnt  = 0;
  int res_cnt  = 0;
  int cfg_cnt  = 0;
  int ovf_cnt  = 0;
  int empty_cnt = 0;
  int pad_cnt  = 0;

  route_transposition_cipher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit blank_char(input logic [15:0] c);
    return (c == 16'h0020) || (c == 16'h0009) || (c == 16'h000A) || (c == 16'h000D);
  endfunction

  function automatic logic [15:0] fold_case(input logic [15:0] c);
    if ((c >= 16'h0061 && c <= 16'h007A) || (c >= 16'h0430 && c <= 16'h044F)) begin
      return c - 16'h0020;
    end
    if (c == 16'h0451) begin
      return 16'h0401;
    end
    return c;
  endfunction

  // Table cell at a row-major position; beyond the text it is a pad
  function automatic logic [15:0] table_cell(input int pos);
    return (pos < fill_cnt) ? text_mem[pos] : PAD_CHAR;
  endfunction

  // Absorb one character; on the closing one, fill route_out with the run
  function automatic void predict_route(input logic [15:0] c, input logic last);
    int cols;
    int rows;
    int i;
    int j;
    logic [15:0] seq [$];
    route_out.delete();
    if (!blank_char(c)) begin
      if (fill_cnt < DEPTH) begin
        text_mem[fill_cnt] = fold_case(c);
        fill_cnt++;
      end else begin
        ovf_seen = 1'b1;
      end
    end
    if (!last) return;
    msg_cnt++;
    if (ovf_seen) begin
      route_out.push_back(RES_OVF);
      ovf_cnt++;
      fill_cnt = 0;
      ovf_seen = 1'b0;
      return;
    end
    if (fill_cnt == 0) begin
      route_out.push_back(RES_EMPTY);
      empty_cnt++;
      return;
    end
    // out-of-range keys clamp to 1..MAX_COLS
    cols = (key_cols == 0) ? 1 : (key_cols > MAX_COLS) ? MAX_COLS : int'(key_cols);
    rows = (fill_cnt + cols - 1) / cols;
    if (!dir_dec) begin
      // read columns right to left, top to bottom
      for (j = cols - 1; j >= 0; j--) begin
        for (i = 0; i < rows; i++) seq.push_back(table_cell(i * cols + j));
      end
    end else begin
      // text was laid down in the encrypt route order; read row by row
      for (i = 0; i < rows; i++) begin
        for (j = 0; j < cols; j++) seq.push_back(table_cell((cols - 1 - j) * rows + i));
      end
      while (seq.size() > 0 && seq[seq.size()-1] == PAD_CHAR) seq.delete(seq.size() - 1);
    end
    fill_cnt = 0;
    ovf_seen = 1'b0;
    if (seq.size() == 0) begin
      route_out.push_back(RES_PAD);
      pad_cnt++;
      return;
    end
    for (i = 0; i < seq.size(); i++) begin
      route_out.push_back('{seq[i], 1'b1, STAT_OK, (i == seq.size() - 1)});
    end
  endfunction

  // Random character, biased toward case-folding edges and whitespace
  function automatic logic [15:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 16'($urandom_range(16'h0061, 16'h007A));
    if (r < 40) return 16'($urandom_range(16'h0041, 16'h005A));
    if (r < 55) return 16'($urandom_range(16'h042F, 16'h0452));
    if (r < 63) begin
      case ($urandom_range(0, 3))
        0: return 16'h0020;
        1: return 16'h0009;
        2: return 16'h000A;
        default: return 16'h000D;
      endcase
    end
    if (r < 70) return ($urandom_range(0, 1) != 0) ? 16'h0058 : 16'h0078;
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return 16'h0060;
        1: return 16'h007B;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offer one character until transferred, then queue its results
  task automatic send_char(input logic [15:0] c, input logic last, input bit typed,
                           input cipher_res_t want);
    int k;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    xfer_cnt++;
    if (!blank_char(c) || last) char_cnt++;
    predict_route(c, last);
    if (typed && last) begin
      expected_q.push_back(want);
    end else begin
      for (k = 0; k < route_out.size(); k++) expected_q.push_back(route_out[k]);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Register write with nothing in flight
  task automatic cfg_write(input logic sel, input logic [5:0] val);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_IDX_COLS) key_cols = val;
    else dir_dec = val[0];
    cfg_cnt++;
  endtask

  // One random message: mostly plain text, some blank-only, overflow, pads
  task automatic send_message();
    int kind;
    int len;
    int n;
    logic [15:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 8) len = $urandom_range(1, 3);
    else if (kind < 20) len = $urandom_range(15, 18);
    else if (kind < 27) len = $urandom_range(1, 6);
    else len = $urandom_range(1, 14);
    for (n = 0; n < len; n++) begin
      if (kind < 8) c = 16'h0020;
      else if (kind < 27 && kind >= 20) c = ($urandom_range(0, 3) == 0) ? 16'h0078 : PAD_CHAR;
      else c = pick_char();
      send_char(c, n == len - 1, 1'b0, RES_NONE);
    end
  endtask

  // Receiver: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    cipher_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      res_cnt++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: data %h user %b last %b",
               out_tdata, out_tuser, out_tlast);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (out_tdata !== want.ch) begin
          $error("out_character: expected %h, got %h", want.ch, out_tdata);
          fail_cnt++;
        end
        if (out_tuser[0] !== want.has) begin
          $error("has_char: expected %b, got %b", want.has, out_tuser[0]);
          fail_cnt++;
        end
        if (out_tuser[2:1] !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_tuser[2:1]);
          fail_cnt++;
        end
        if (out_tlast !== want.eom) begin
          $error("end_of_message: expected %b, got %b", want.eom, out_tlast);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int r;
    int n;
    int ph;
    int start;
    int phase_idle [4]  = '{0, 70, 0, 31};
    int phase_stall [4] = '{0, 0, 70, 31};
    logic [5:0] phase_key [4] = '{6'd1, 6'd50, 6'd63, 6'd0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (r = 0; r < N_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        cfg_write(dir_rows[r].sel, dir_rows[r].data[5:0]);
      end else begin
        for (n = 1; n <= dir_rows[r].reps; n++) begin
          send_char(dir_rows[r].data, dir_rows[r].last && (n == dir_rows[r].reps),
                    dir_rows[r].typed, dir_rows[r].want);
        end
      end
    end

    // Random phases with different idle and stall mixes
    for (ph = 0; ph < 4; ph++) begin
      cfg_write(CFG_IDX_COLS, phase_key[ph]);
      cfg_write(CFG_IDX_DIR, 6'(ph % 2));
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      if (ph == 0) hold_req = 1'b1;
      start = char_cnt;
      while (char_cnt - start < PHASE_LEN) begin
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) != 0) begin
            cfg_write(CFG_IDX_DIR, 6'($urandom_range(0, 1)));
          end else if ($urandom_range(0, 3) == 0) begin
            cfg_write(CFG_IDX_COLS, 6'($urandom_range(0, 63)));
          end else begin
            cfg_write(CFG_IDX_COLS, 6'($urandom_range(1, 6)));
          end
        end
        send_message();
      end
    end

    drain();
    repeat (TAIL) @(posedge clk);
    $display("Covered %0d transfers in %0d messages, %0d results checked, %0d register writes",
             xfer_cnt, msg_cnt, res_cnt, cfg_cnt);
    $display("Error runs: %0d overflow, %0d empty; %0d decrypts with padding only",
             ovf_cnt, empty_cnt, pad_cnt);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
